### sv/vlan_tag_count_rewriter_assert.svh
// assertion macros for the vlan tag count rewriter
// uses the clk_i and rst_ni ports of the module that includes it
`ifndef VLAN_TAG_COUNT_REWRITER_ASSERT_SVH
`define VLAN_TAG_COUNT_REWRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define VTCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vtcr assertion failed");
`define VTCR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("vtcr forbidden condition");
`else
`define VTCR_ASSERT(lbl, prop)
`define VTCR_NEVER(lbl, expr)
`endif

`endif

### sv/vtcr_pkg.sv
// shared types and constants for the vlan tag count rewriter
// no dependencies
package vtcr_pkg;

  localparam int unsigned PosW = 5;
  localparam logic [PosW-1:0] MacBytes = 5'd12;
  localparam logic [PosW-1:0] PosMax = 5'd31;
  localparam logic [PosW-1:0] OuterCtlHi = 5'd14;
  localparam logic [PosW-1:0] OuterCtlLo = 5'd15;
  localparam logic [PosW-1:0] InnerCtlHi = 5'd18;
  localparam logic [PosW-1:0] InnerCtlLo = 5'd19;
  localparam logic [7:0] TpidHi = 8'h81;
  localparam logic [7:0] TpidLo = 8'h00;
  localparam logic [3:0] TagSeqMax = 4'd12;

  // how one accepted byte is handled
  typedef struct packed {
    logic       drop;     // byte gives no result
    logic       err;      // frame ended before the end of its source tags
    logic [3:0] ins_cnt;  // tag bytes sent ahead of this byte
  } byte_cls_t;

  // byte number idx of the inserted tag sequence
  function automatic logic [7:0] tag_byte(input logic [3:0] idx, input logic [31:0] kept);
    logic [1:0] sel;
    logic [7:0] res;
    sel = {idx[2], idx[0]};
    res = 8'h00;
    case (idx[1:0])
      2'd0: res = TpidHi;
      2'd1: res = TpidLo;
      default: res = idx[3] ? 8'h00 : kept[{sel, 3'b000} +: 8];
    endcase
    return res;
  endfunction

endpackage

### sv/vtcr_frame_track.sv
// frame tracker: byte position, sampled formats, kept tag control words
// and the per-byte classification; depends on vtcr_pkg
module vtcr_frame_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic [1:0]         source_format_i,
  input  logic [1:0]         target_format_i,
  output vtcr_pkg::byte_cls_t cls_o,
  output logic [31:0]        kept_o
);
  import vtcr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      src_q, src_d, tgt_q, tgt_d;
  logic [31:0]     kept_q, kept_d;
  logic [1:0]      src, tgt;
  logic [PosW-1:0] tag_end;
  logic            first;

  assign first   = (pos_q == '0);
  assign src     = first ? source_format_i : src_q;
  assign tgt     = first ? target_format_i : tgt_q;
  assign tag_end = MacBytes + {1'b0, src, 2'b00};

  always_comb begin
    cls_o = '0;
    if (src != tgt) begin
      if (pos_q < tag_end) begin
        if (last_byte_i) begin
          cls_o.err = 1'b1;
        end else if (pos_q >= MacBytes) begin
          cls_o.drop = 1'b1;
        end
      end else if (pos_q == tag_end) begin
        cls_o.ins_cnt = {tgt, 2'b00};
      end
    end
  end

  always_comb begin
    pos_d  = pos_q;
    src_d  = src_q;
    tgt_d  = tgt_q;
    kept_d = kept_q;
    if (acc_i) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + 5'd1;
      end
      if (first) begin
        src_d  = source_format_i;
        tgt_d  = target_format_i;
        kept_d = '0;
      end
      // capture control words of the dropped outer and second tags
      if (cls_o.drop) begin
        if (pos_q == OuterCtlHi) begin
          kept_d[7:0] = data_byte_i;
        end else if (pos_q == OuterCtlLo) begin
          kept_d[15:8] = data_byte_i;
        end else if (src[1] && pos_q == InnerCtlHi) begin
          kept_d[23:16] = data_byte_i;
        end else if (src[1] && pos_q == InnerCtlLo) begin
          kept_d[31:24] = data_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      src_q  <= '0;
      tgt_q  <= '0;
      kept_q <= '0;
    end else begin
      pos_q  <= pos_d;
      src_q  <= src_d;
      tgt_q  <= tgt_d;
      kept_q <= kept_d;
    end
  end

  assign kept_o = kept_q;

endmodule

### sv/vlan_tag_count_rewriter.sv
// top level of the vlan tag count rewriter: byte stage and output register
// depends on vtcr_pkg, vtcr_frame_track and vlan_tag_count_rewriter_assert.svh
//
// Usage: frame bytes enter on the in_valid_i / in_ready_o channel, one byte
// per request, with last_byte_i on the final byte; source_format_i and
// target_format_i are sampled on the first byte of each frame. Rewritten
// bytes leave on out_valid_o / out_ready_i with out_last_o and error_o.
// An accepted byte is loaded into the byte stage and from there into the
// output register, where it can be taken. Dropped tag bytes give no output.
// Throughput is one byte per cycle while the receiver is ready; when the
// formats differ, the byte that follows the source tags holds the byte stage
// while the 4 * target_format new tag bytes are sent, so input is stalled
// then, once per frame. A frame with differing formats that ends before the
// end of its source tags gives one byte 0 with out_last_o and error_o set.
// Reset empties both stages, restarts frame tracking and clears the kept
// control words. When the receiver stalls, the output register holds and
// the byte stage takes one more request before in_ready_o drops.
`include "vlan_tag_count_rewriter_assert.svh"

module vlan_tag_count_rewriter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic [1:0] source_format_i,
  input  logic [1:0] target_format_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       error_o
);
  import vtcr_pkg::*;

  byte_cls_t   cls;
  logic [31:0] kept;
  logic        acc, load, out_free, emit, fin;

  logic       st_valid_q, st_valid_d;
  logic [7:0] st_data_q, st_data_d;
  logic       st_last_q, st_last_d;
  logic       st_err_q, st_err_d;
  logic [3:0] st_left_q, st_left_d;
  logic [3:0] st_idx_q, st_idx_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_err_q, out_err_d;

  vtcr_frame_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .source_format_i (source_format_i),
    .target_format_i (target_format_i),
    .cls_o           (cls),
    .kept_o          (kept)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = st_valid_q && out_free;
  assign fin        = emit && (st_left_q == '0);
  assign in_ready_o = !st_valid_q || fin;
  assign acc        = in_valid_i && in_ready_o;
  assign load       = acc && !cls.drop;

  // byte stage: sends pending tag bytes first, then the held byte
  always_comb begin
    st_valid_d = st_valid_q;
    st_data_d  = st_data_q;
    st_last_d  = st_last_q;
    st_err_d   = st_err_q;
    st_left_d  = st_left_q;
    st_idx_d   = st_idx_q;
    if (load) begin
      st_valid_d = 1'b1;
      st_data_d  = cls.err ? 8'h00 : data_byte_i;
      st_last_d  = cls.err | last_byte_i;
      st_err_d   = cls.err;
      st_left_d  = cls.ins_cnt;
      st_idx_d   = '0;
    end else if (fin) begin
      st_valid_d = 1'b0;
    end else if (emit) begin
      st_left_d = st_left_q - 4'd1;
      st_idx_d  = st_idx_q + 4'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (out_free) begin
      out_valid_d = st_valid_q;
      if (st_left_q != '0) begin
        out_byte_d = tag_byte(st_idx_q, kept);
        out_last_d = 1'b0;
        out_err_d  = 1'b0;
      end else begin
        out_byte_d = st_data_q;
        out_last_d = st_last_q;
        out_err_d  = st_err_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      st_left_q   <= '0;
      st_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_valid_q  <= st_valid_d;
      st_left_q   <= st_left_d;
      st_idx_q    <= st_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_data_q  <= st_data_d;
    st_last_q  <= st_last_d;
    st_err_q   <= st_err_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign error_o     = out_err_q;

  `VTCR_NEVER(a_no_req_during_tags, (st_left_q != '0) && in_ready_o)
  `VTCR_ASSERT(a_err_ends_frame, out_valid_q && out_err_q |-> out_last_q)
  `VTCR_ASSERT(a_tag_seq_bound, st_valid_q |-> (5'(st_left_q) + 5'(st_idx_q)) <= 5'(TagSeqMax))
  `VTCR_NEVER(a_tags_need_stage, (st_left_q != '0) && !st_valid_q)

endmodule
